>>> rtl/core/byte_ring_buffer_with_compaction_assert.svh
// ----------------------------------------------------------------------------
// Byte ring buffer assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_WITH_COMPACTION_ASSERT_SVH
`define BYTE_RING_BUFFER_WITH_COMPACTION_ASSERT_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define BRB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("byte ring buffer: same-cycle check failed");
// Check cons in the cycle after ante.
`define BRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("byte ring buffer: next-cycle check failed");
`else
`define BRB_ASSERT_SAME(label, ante, cons)
`define BRB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/core/brb_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring buffer package
// Field widths, operation codes and the memory request type.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int OP_W       = 3;
  localparam int LEN_W      = 13;
  localparam int POS_W      = 12;
  localparam int DATA_W     = 8;
  localparam int MEM_AW_MAX = 16;

  localparam logic [OP_W-1:0] OP_STORE     = 3'd0;
  localparam logic [OP_W-1:0] OP_COMMIT_WR = 3'd1;
  localparam logic [OP_W-1:0] OP_COMMIT_RD = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAN     = 3'd3;
  localparam logic [OP_W-1:0] OP_READ      = 3'd4;

  // One read and one write into the two-bank byte store.
  typedef struct packed {
    logic                  rd_en;
    logic                  rd_bank;
    logic [MEM_AW_MAX-1:0] rd_addr;
    logic                  wr_en;
    logic                  wr_bank;
    logic [MEM_AW_MAX-1:0] wr_addr;
    logic [DATA_W-1:0]     wr_data;
  } brb_mem_req_t;

endpackage

>>> rtl/core/brb_if.sv
// ----------------------------------------------------------------------------
// Byte ring buffer channels
// Valid/ready request channel and result channel.
// ----------------------------------------------------------------------------
interface brb_in_if import brb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [LEN_W-1:0]  length;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] data_byte;

  modport source (output valid, output op, output length, output position,
                  output data_byte, input ready);
  modport sink   (input valid, input op, input length, input position,
                  input data_byte, output ready);
endinterface

interface brb_out_if import brb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [DATA_W-1:0] data_out;
  logic [LEN_W-1:0]  used_bytes;
  logic [POS_W-1:0]  read_pos;
  logic [POS_W-1:0]  write_pos;
  logic [LEN_W-1:0]  contig_read;
  logic [LEN_W-1:0]  contig_free;

  modport source (output valid, output ok, output data_out, output used_bytes,
                  output read_pos, output write_pos, output contig_read,
                  output contig_free, input ready);
  modport sink   (input valid, input ok, input data_out, input used_bytes,
                  input read_pos, input write_pos, input contig_read,
                  input contig_free, output ready);
endinterface

>>> rtl/core/brb_store.sv
// ----------------------------------------------------------------------------
// Byte ring buffer store
// Two banks of DEPTH bytes, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module brb_store import brb_pkg::*; #(
  parameter int DEPTH = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  brb_mem_req_t      req,
  output logic [DATA_W-1:0] rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [DATA_W-1:0] bank0 [DEPTH];
  logic [DATA_W-1:0] bank1 [DEPTH];
  logic [DATA_W-1:0] rd0_r;
  logic [DATA_W-1:0] rd1_r;
  logic              sel_r;

  always_ff @(posedge clk) begin
    if (req.wr_en && !req.wr_bank) begin
      bank0[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd0_r <= bank0[req.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en && req.wr_bank) begin
      bank1[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd1_r <= bank1[req.rd_addr[AW-1:0]];
    end
  end

  // Hold the bank of the last read to steer its data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else if (req.rd_en) begin
      sel_r <= req.rd_bank;
    end
  end

  assign rd_data = sel_r ? rd1_r : rd0_r;

endmodule

>>> rtl/core/byte_ring_buffer_with_compaction.sv
// ----------------------------------------------------------------------------
// Byte ring buffer with compaction
// CAPACITY-byte circular buffer with store, commit, read and clean requests.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   in_ch     sink       valid/ready          op, length, position, data_byte
//   out_ch    source     valid/ready          ok, data_out, used_bytes,
//                                             read_pos, write_pos,
//                                             contig_read, contig_free
//
// Store, commit, refused and plain clean requests: result registered at the
// accepting edge. Read byte: the store's registered read feeds the result
// from S_RD. Clean with compaction: one byte a cycle copied from the active
// bank into the other bank through its single read port, after which the
// banks swap roles. Reset (rst_n, synchronous) clears offsets, count and
// control; the byte store has no clearing pass. in_ch.ready drops while a
// request is in flight and while a finished result waits in the output
// register with out_ch.ready low.

`include "byte_ring_buffer_with_compaction_assert.svh"

module byte_ring_buffer_with_compaction import brb_pkg::*; #(
  parameter int CAPACITY = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  brb_in_if.sink    in_ch,
  brb_out_if.source out_ch
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > LEN_W) ? CW : LEN_W) + 1;

  localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
  localparam logic [XW-1:0] CAP_X     = XW'(CAPACITY);
  localparam logic [CW-1:0] QUARTER_C = CW'(CAPACITY / 4);
  localparam logic [AW-1:0] LAST_IDX  = AW'(CAPACITY - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_COPY = 2'd2;
  localparam logic [1:0] S_CFIN = 2'd3;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data_out;
    logic [LEN_W-1:0]  used_bytes;
    logic [POS_W-1:0]  read_pos;
    logic [POS_W-1:0]  write_pos;
    logic [LEN_W-1:0]  contig_read;
    logic [LEN_W-1:0]  contig_free;
  } brb_result_t;

  // base + delta modulo CAPACITY; callers keep delta within CAPACITY
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [XW-1:0] delta);
    logic [XW-1:0] sum;
    sum = XW'(base) + delta;
    if (sum >= CAP_X) begin
      sum = sum - CAP_X;
    end
    return AW'(sum);
  endfunction

  function automatic brb_result_t make_result(input logic              ok,
                                              input logic [DATA_W-1:0] data,
                                              input logic [CW-1:0]     used,
                                              input logic [AW-1:0]     ro,
                                              input logic [AW-1:0]     wo);
    logic [CW-1:0] to_end_rd;
    logic [CW-1:0] to_end_wr;
    logic [CW-1:0] free_b;
    brb_result_t   r;
    to_end_rd     = CAP_C - CW'(ro);
    to_end_wr     = CAP_C - CW'(wo);
    free_b        = CAP_C - used;
    r.ok          = ok;
    r.data_out    = data;
    r.used_bytes  = LEN_W'(used);
    r.read_pos    = POS_W'(ro);
    r.write_pos   = POS_W'(wo);
    r.contig_read = LEN_W'((used < to_end_rd) ? used : to_end_rd);
    r.contig_free = LEN_W'((free_b < to_end_wr) ? free_b : to_end_wr);
    return r;
  endfunction

  // Control and offset state
  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] ro_r, ro_nxt;
  logic [AW-1:0] wo_r, wo_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic          bank_r, bank_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          cp_wv_r, cp_wv_nxt;
  logic [AW-1:0] cp_wa_r, cp_wa_nxt;
  logic          out_valid_r, out_valid_nxt;
  brb_result_t   res_r, res_nxt;

  brb_mem_req_t      mem_req;
  logic [DATA_W-1:0] mem_rd_data;

  logic              in_fire;
  logic [CW-1:0]     free_c;
  logic [XW-1:0]     pos_x, len_x, used_x, free_x;
  logic              store_ok, wr_ok, rd_ok, rdb_ok;
  logic [AW-1:0]     store_addr, rdb_addr, wr_wo, rd_ro, copy_src;
  logic              load_res, res_ok;
  logic [DATA_W-1:0] res_data;

  brb_store #(.DEPTH(CAPACITY)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  // Accept only in idle with room in the output register.
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Range checks against free space and used count
  assign free_c   = CAP_C - used_r;
  assign pos_x    = XW'(in_ch.position);
  assign len_x    = XW'(in_ch.length);
  assign used_x   = XW'(used_r);
  assign free_x   = XW'(free_c);
  assign store_ok = pos_x < free_x;
  assign wr_ok    = len_x <= free_x;
  assign rd_ok    = len_x <= used_x;
  assign rdb_ok   = pos_x < used_x;

  assign store_addr = wrap_add(wo_r, pos_x);
  assign rdb_addr   = wrap_add(ro_r, pos_x);
  assign wr_wo      = wrap_add(wo_r, len_x);
  assign rd_ro      = wrap_add(ro_r, len_x);

  // Compaction source: held bytes come rotated, the tail stays in place.
  assign copy_src = (CW'(cnt_r) < used_r) ? wrap_add(ro_r, XW'(cnt_r)) : cnt_r;

  always_comb begin
    state_nxt     = state_r;
    ro_nxt        = ro_r;
    wo_nxt        = wo_r;
    used_nxt      = used_r;
    bank_nxt      = bank_r;
    cnt_nxt       = cnt_r;
    cp_wv_nxt     = cp_wv_r;
    cp_wa_nxt     = cp_wa_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_nxt       = res_r;
    load_res      = 1'b0;
    res_ok        = 1'b0;
    res_data      = '0;
    mem_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.op)
            OP_STORE: begin
              load_res = 1'b1;
              res_ok   = store_ok;
              if (store_ok) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_bank = bank_r;
                mem_req.wr_addr = MEM_AW_MAX'(store_addr);
                mem_req.wr_data = in_ch.data_byte;
              end
            end
            OP_COMMIT_WR: begin
              load_res = 1'b1;
              res_ok   = wr_ok;
              if (wr_ok) begin
                wo_nxt   = wr_wo;
                used_nxt = used_r + CW'(in_ch.length);
              end
            end
            OP_COMMIT_RD: begin
              load_res = 1'b1;
              res_ok   = rd_ok;
              if (rd_ok) begin
                ro_nxt   = rd_ro;
                used_nxt = used_r - CW'(in_ch.length);
              end
            end
            OP_CLEAN: begin
              if (used_r == '0) begin
                load_res = 1'b1;
                res_ok   = 1'b1;
                ro_nxt   = '0;
                wo_nxt   = '0;
              end else if (free_c < QUARTER_C) begin
                state_nxt = S_COPY;
                cnt_nxt   = '0;
              end else begin
                load_res = 1'b1;
                res_ok   = 1'b1;
              end
            end
            OP_READ: begin
              if (rdb_ok) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_bank = bank_r;
                mem_req.rd_addr = MEM_AW_MAX'(rdb_addr);
                state_nxt       = S_RD;
              end else begin
                load_res = 1'b1;
              end
            end
            default: begin
              load_res = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        // Byte arrives in the cycle after the read was issued.
        load_res  = 1'b1;
        res_ok    = 1'b1;
        res_data  = mem_rd_data;
        state_nxt = S_IDLE;
      end
      S_COPY: begin
        // Read one byte a cycle; its write to the other bank follows.
        mem_req.rd_en   = 1'b1;
        mem_req.rd_bank = bank_r;
        mem_req.rd_addr = MEM_AW_MAX'(copy_src);
        cp_wv_nxt       = 1'b1;
        cp_wa_nxt       = cnt_r;
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_CFIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_CFIN: begin
        // Last byte lands now; swap banks and rebase the offsets.
        cp_wv_nxt = 1'b0;
        bank_nxt  = !bank_r;
        ro_nxt    = '0;
        wo_nxt    = (used_r == CAP_C) ? '0 : AW'(used_r);
        load_res  = 1'b1;
        res_ok    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Compaction write stage into the inactive bank
    if (cp_wv_r) begin
      mem_req.wr_en   = 1'b1;
      mem_req.wr_bank = !bank_r;
      mem_req.wr_addr = MEM_AW_MAX'(cp_wa_r);
      mem_req.wr_data = mem_rd_data;
    end

    if (load_res) begin
      out_valid_nxt = 1'b1;
      res_nxt       = make_result(res_ok, res_data, used_nxt, ro_nxt, wo_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ro_r        <= '0;
      wo_r        <= '0;
      used_r      <= '0;
      bank_r      <= 1'b0;
      cp_wv_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ro_r        <= ro_nxt;
      wo_r        <= wo_nxt;
      used_r      <= used_nxt;
      bank_r      <= bank_nxt;
      cp_wv_r     <= cp_wv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    cp_wa_r <= cp_wa_nxt;
    res_r   <= res_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = res_r.ok;
  assign out_ch.data_out    = res_r.data_out;
  assign out_ch.used_bytes  = res_r.used_bytes;
  assign out_ch.read_pos    = res_r.read_pos;
  assign out_ch.write_pos   = res_r.write_pos;
  assign out_ch.contig_read = res_r.contig_read;
  assign out_ch.contig_free = res_r.contig_free;

  // Used count never passes capacity.
  `BRB_ASSERT_SAME(a_used_bound, 1'b1, used_r <= CAP_C)
  // A read waits on an empty output register.
  `BRB_ASSERT_SAME(a_rd_out_free, state_r == S_RD, !out_valid_r)
  // Compaction finish rebases the read offset and posts a result.
  `BRB_ASSERT_NEXT(a_cfin_rebase, state_r == S_CFIN, (ro_r == '0) && out_valid_r)
  // Copy writes happen only while compacting.
  `BRB_ASSERT_SAME(a_copy_wr, cp_wv_r, (state_r == S_COPY) || (state_r == S_CFIN))

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring buffer with compaction: regression bench
// Drives store, commit, read and clean requests through the request channel
// and checks every result against a typed value or a cycle-free predictor of
// the ring. The run opens with a table of directed requests, then randomized
// traffic whose lengths and positions follow the predicted fill level. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top import brb_pkg::*; ();

  localparam int CAPACITY = 4096;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned REPORT_LIMIT = 10;
  // Slowest legal quiet stretch is one compaction pass plus the longest
  // stall on either side; allow several times that.
  localparam int unsigned WATCHDOG_CYCLES = 5 * (CAPACITY + 2) + 1000;
  localparam int unsigned DRAIN_CYCLES = 32;

  // Operation codes the block does not define; each must be refused.
  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [LEN_W-1:0]  length;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] data_byte;
  } ring_req_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data_out;
    logic [LEN_W-1:0]  used_bytes;
    logic [POS_W-1:0]  read_pos;
    logic [POS_W-1:0]  write_pos;
    logic [LEN_W-1:0]  contig_read;
    logic [LEN_W-1:0]  contig_free;
  } ring_result_t;

  // ROW_TYPED rows carry a hand-written result, ROW_PREDICTED rows take the
  // predictor's, ROW_FILL stores every byte of the ring once.
  typedef enum logic [1:0] {ROW_TYPED, ROW_PREDICTED, ROW_FILL} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    ring_req_t    req;
    ring_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  brb_in_if  in_ch ();
  brb_out_if out_ch ();

  byte_ring_buffer_with_compaction #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predicted ring contents and pointers
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] ring_mem [CAPACITY];
  int unsigned ring_rd   = 0;
  int unsigned ring_wr   = 0;
  int unsigned ring_held = 0;

  ring_result_t expected_results [$];
  stim_row_t    directed_plan [$];
  int unsigned  mismatch_count = 0;
  int unsigned  results_seen   = 0;
  int unsigned  calm_left      = 0;
  int unsigned  stall_cycles   = 0;

  function automatic int unsigned min_u(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // Apply one accepted request to the predicted ring and return its result.
  function automatic ring_result_t ring_apply(ring_req_t r);
    ring_result_t      res;
    int unsigned       free_b;
    int unsigned       len;
    int unsigned       pos;
    logic [DATA_W-1:0] rotated [CAPACITY];

    res    = '0;
    free_b = CAPACITY - ring_held;
    len    = r.length;
    pos    = r.position;
    case (r.op)
      OP_STORE: begin
        if (pos < free_b) begin
          ring_mem[(ring_wr + pos) % CAPACITY] = r.data_byte;
          res.ok = 1'b1;
        end
      end
      OP_COMMIT_WR: begin
        if (len <= free_b) begin
          ring_wr   = (ring_wr + len) % CAPACITY;
          ring_held = ring_held + len;
          res.ok    = 1'b1;
        end
      end
      OP_COMMIT_RD: begin
        if (len <= ring_held) begin
          ring_rd   = (ring_rd + len) % CAPACITY;
          ring_held = ring_held - len;
          res.ok    = 1'b1;
        end
      end
      OP_CLEAN: begin
        if (ring_held == 0) begin
          ring_rd = 0;
          ring_wr = 0;
        end else if (free_b < CAPACITY / 4) begin
          // Rotate the held bytes down to address 0; bytes past the held
          // region keep what they had.
          for (int i = 0; i < ring_held; i++) rotated[i] = ring_mem[(ring_rd + i) % CAPACITY];
          for (int i = 0; i < ring_held; i++) ring_mem[i] = rotated[i];
          ring_rd = 0;
          ring_wr = ring_held % CAPACITY;
        end
        res.ok = 1'b1;
      end
      OP_READ: begin
        if (pos < ring_held) begin
          res.data_out = ring_mem[(ring_rd + pos) % CAPACITY];
          res.ok       = 1'b1;
        end
      end
      default: ;
    endcase
    free_b          = CAPACITY - ring_held;
    res.used_bytes  = LEN_W'(ring_held);
    res.read_pos    = POS_W'(ring_rd);
    res.write_pos   = POS_W'(ring_wr);
    res.contig_read = LEN_W'(min_u(ring_held, CAPACITY - ring_rd));
    res.contig_free = LEN_W'(min_u(free_b, CAPACITY - ring_wr));
    return res;
  endfunction

  function automatic ring_req_t make_req(logic [OP_W-1:0] op, int unsigned len,
                                         int unsigned pos, int unsigned data);
    ring_req_t r;
    r.op        = op;
    r.length    = LEN_W'(len);
    r.position  = POS_W'(pos);
    r.data_byte = DATA_W'(data);
    return r;
  endfunction

  function automatic void add_typed(logic [OP_W-1:0] op, int unsigned len, int unsigned pos,
                                    int unsigned data, bit ok, int unsigned used,
                                    int unsigned rd, int unsigned wr, int unsigned cr,
                                    int unsigned cf);
    stim_row_t row;
    row.kind             = ROW_TYPED;
    row.req              = make_req(op, len, pos, data);
    row.want             = '0;
    row.want.ok          = ok;
    row.want.used_bytes  = LEN_W'(used);
    row.want.read_pos    = POS_W'(rd);
    row.want.write_pos   = POS_W'(wr);
    row.want.contig_read = LEN_W'(cr);
    row.want.contig_free = LEN_W'(cf);
    directed_plan.push_back(row);
  endfunction

  function automatic void add_predicted(row_kind_t kind, logic [OP_W-1:0] op,
                                        int unsigned pos);
    stim_row_t row;
    row.kind = kind;
    row.req  = make_req(op, 0, pos, 0);
    row.want = '0;
    directed_plan.push_back(row);
  endfunction

  // Mostly back-to-back, sometimes a short gap, now and then a long pause.
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Build a random request that fits the predicted fill level most of the
  // time, with a share of out-of-range positions and oversize lengths.
  function automatic ring_req_t pick_request();
    ring_req_t   r;
    int unsigned free_b;
    int unsigned roll;
    int unsigned shape;

    r.op        = OP_STORE;
    r.length    = LEN_W'($urandom);
    r.position  = POS_W'($urandom);
    r.data_byte = DATA_W'($urandom);
    free_b      = CAPACITY - ring_held;
    roll        = $urandom_range(0, 99);
    shape       = $urandom_range(0, 9);
    if (roll < 30) begin
      r.op = OP_STORE;
      if (free_b > 0 && shape != 0) r.position = POS_W'($urandom_range(0, free_b - 1));
    end else if (roll < 50) begin
      r.op = OP_COMMIT_WR;
      // Fill the ring completely now and then to reach full and compaction.
      if (shape == 1 || shape == 2) r.length = LEN_W'(free_b);
      else if (shape != 0) r.length = LEN_W'($urandom_range(0, free_b));
    end else if (roll < 68) begin
      r.op = OP_COMMIT_RD;
      if (shape == 1) r.length = LEN_W'(ring_held);
      else if (shape != 0) r.length = LEN_W'($urandom_range(0, ring_held));
    end else if (roll < 90) begin
      r.op = OP_READ;
      if (ring_held > 0 && shape != 0) r.position = POS_W'($urandom_range(0, ring_held - 1));
    end else if (roll < 97) begin
      r.op = OP_CLEAN;
    end else begin
      r.op = OP_W'($urandom_range(OP_RSVD_A, OP_RSVD_C));
    end
    return r;
  endfunction

  // Present one request, hold it until accepted, record its expected result
  // and then idle the channel for a random gap.
  task automatic send_request(ring_req_t r, bit typed, ring_result_t want);
    ring_result_t predicted;
    int unsigned  gap;

    in_ch.valid     <= 1'b1;
    in_ch.op        <= r.op;
    in_ch.length    <= r.length;
    in_ch.position  <= r.position;
    in_ch.data_byte <= r.data_byte;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = ring_apply(r);
    expected_results.push_back(typed ? want : predicted);
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = idle_cycles();
      if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed table, random traffic, drain
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OP_STORE;
    in_ch.length    <= '0;
    in_ch.position  <= '0;
    in_ch.data_byte <= '0;

    // Empty ring: refusals, reserved codes, extreme field values.
    add_typed(OP_READ,      0,    0,    0,   1'b0, 0, 0, 0, 0, CAPACITY);
    add_typed(OP_COMMIT_RD, 1,    0,    0,   1'b0, 0, 0, 0, 0, CAPACITY);
    add_typed(OP_COMMIT_WR, 8191, 0,    0,   1'b0, 0, 0, 0, 0, CAPACITY);
    add_typed(OP_RSVD_A,    8191, 4095, 255, 1'b0, 0, 0, 0, 0, CAPACITY);
    add_typed(OP_RSVD_B,    0,    0,    0,   1'b0, 0, 0, 0, 0, CAPACITY);
    add_typed(OP_RSVD_C,    4096, 2048, 170, 1'b0, 0, 0, 0, 0, CAPACITY);
    add_typed(OP_STORE,     0,    4095, 255, 1'b1, 0, 0, 0, 0, CAPACITY);
    add_typed(OP_STORE,     8191, 0,    0,   1'b1, 0, 0, 0, 0, CAPACITY);
    add_typed(OP_COMMIT_WR, 0,    0,    0,   1'b1, 0, 0, 0, 0, CAPACITY);
    add_typed(OP_COMMIT_RD, 0,    0,    0,   1'b1, 0, 0, 0, 0, CAPACITY);
    add_typed(OP_CLEAN,     0,    0,    0,   1'b1, 0, 0, 0, 0, CAPACITY);
    // Write every byte once so later commits and rotations never touch
    // storage that holds no data.
    add_predicted(ROW_FILL, OP_STORE, 0);
    // Full ring: store and commit refused, spans at their limits.
    add_typed(OP_COMMIT_WR, 4096, 0, 0, 1'b1, 4096, 0, 0, 4096, 0);
    add_typed(OP_STORE,     0,    0, 0, 1'b0, 4096, 0, 0, 4096, 0);
    add_typed(OP_COMMIT_WR, 1,    0, 0, 1'b0, 4096, 0, 0, 4096, 0);
    add_predicted(ROW_PREDICTED, OP_READ, 4095);
    add_typed(OP_COMMIT_RD, 4097, 0, 0, 1'b0, 4096, 0, 0, 4096, 0);
    // Full and wrapped: clean rotates everything and parks write at 0.
    add_typed(OP_COMMIT_RD, 100,  0, 0, 1'b1, 3996, 100, 0,   3996, 100);
    add_typed(OP_COMMIT_WR, 100,  0, 0, 1'b1, 4096, 100, 100, 3996, 0);
    add_typed(OP_CLEAN,     0,    0, 0, 1'b1, 4096, 0,   0,   4096, 0);
    add_predicted(ROW_PREDICTED, OP_READ, 0);
    // Plenty of free space: clean leaves a non-empty ring alone.
    add_typed(OP_COMMIT_RD, 3000, 0, 0, 1'b1, 1096, 3000, 0,    1096, 3000);
    add_typed(OP_CLEAN,     0,    0, 0, 1'b1, 1096, 3000, 0,    1096, 3000);
    // Wrapped and nearly full: clean compacts across the end of the store.
    add_typed(OP_COMMIT_WR, 2500, 0, 0, 1'b1, 3596, 3000, 2500, 1096, 500);
    add_typed(OP_CLEAN,     0,    0, 0, 1'b1, 3596, 0,    3596, 3596, 500);
    add_predicted(ROW_PREDICTED, OP_READ, 3595);
    // Drain, then clean on empty resets both offsets.
    add_typed(OP_COMMIT_RD, 3596, 0, 0, 1'b1, 0, 3596, 3596, 0, 500);
    add_typed(OP_CLEAN,     0,    0, 0, 1'b1, 0, 0,    0,    0, CAPACITY);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      case (directed_plan[i].kind)
        ROW_FILL: begin
          for (int a = 0; a < CAPACITY; a++) begin
            send_request(make_req(OP_STORE, 0, a, $urandom_range(0, 255)), 1'b0, '0);
          end
        end
        ROW_TYPED: send_request(directed_plan[i].req, 1'b1, directed_plan[i].want);
        default:   send_request(directed_plan[i].req, 1'b0, '0);
      endcase
    end

    repeat (RANDOM_ITEMS) send_request(pick_request(), 1'b0, '0);
    in_ch.valid <= 1'b0;

    // Wait out the outstanding results, then watch for strays.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("byte_ring_buffer_with_compaction regression: pass");
    end else begin
      $display("byte_ring_buffer_with_compaction regression: fail");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random backpressure with long open stretches
  // --------------------------------------------------------------------------
  initial begin : result_backpressure
    int unsigned gap;
    int unsigned open_len;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      open_len = ($urandom_range(0, 99) < 15) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      repeat (open_len) @(posedge clk);
      gap = idle_cycles();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each accepted result with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    ring_result_t got;
    ring_result_t want;
    bit           bad;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.ok          = out_ch.ok;
      got.data_out    = out_ch.data_out;
      got.used_bytes  = out_ch.used_bytes;
      got.read_pos    = out_ch.read_pos;
      got.write_pos   = out_ch.write_pos;
      got.contig_read = out_ch.contig_read;
      got.contig_free = out_ch.contig_free;
      if (expected_results.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT) begin
          $display("result %0d arrived with no request outstanding", results_seen);
        end
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        bad  = (got.ok !== want.ok) || (got.data_out !== want.data_out) ||
               (got.used_bytes !== want.used_bytes) || (got.read_pos !== want.read_pos) ||
               (got.write_pos !== want.write_pos) ||
               (got.contig_read !== want.contig_read) ||
               (got.contig_free !== want.contig_free);
        if (bad) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("result %0d mismatch", results_seen);
            $display("  expected ok=%0d data=%02h used=%0d rd=%0d wr=%0d span_rd=%0d span_free=%0d",
                     want.ok, want.data_out, want.used_bytes, want.read_pos, want.write_pos,
                     want.contig_read, want.contig_free);
            $display("  actual   ok=%0d data=%02h used=%0d rd=%0d wr=%0d span_rd=%0d span_free=%0d",
                     got.ok, got.data_out, got.used_bytes, got.read_pos, got.write_pos,
                     got.contig_read, got.contig_free);
          end
          mismatch_count++;
        end
      end
      results_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no request or result moves for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_CYCLES) begin
        $display("byte_ring_buffer_with_compaction regression: fail");
        $finish;
      end
    end
  end

endmodule
